// ===== hdl/glwm_pkg.sv =====
// Package for the grain last-writer map: sizes, command codes, FSM states and shared structs.
`timescale 1ns / 1ps

package glwm_pkg;

    localparam int GRAIN_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(GRAIN_DEPTH);
    localparam int SIZE_W      = ADDR_W + 1;
    localparam int ID_WIDTH    = 16;
    localparam logic [ID_WIDTH-1:0] ID_MAX = {ID_WIDTH{1'b1}};

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_TEST  = 2'd1,
        CMD_POP   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_PUSH,
        ST_TEST,
        ST_POP,
        ST_CLEAR,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                re;
        logic [ADDR_W-1:0]   raddr;
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [ID_WIDTH-1:0] wdata;
    } ram_req_t;

    typedef struct packed {
        logic                kind;
        logic                may_write;
        logic                run_found;
        logic [ID_WIDTH-1:0] run_id;
        logic [ADDR_W-1:0]   run_start;
        logic [SIZE_W-1:0]   run_length;
    } result_t;

endpackage

// ===== hdl/grain_last_writer_map.sv =====
// Top level of the grain last-writer map: command sequencer around the owner table.
`timescale 1ns / 1ps

// Tracks the latest writer of each grain of one region in a 4096-entry table.
// After reset the block zeroes the table, one entry per cycle; commands are not
// taken during that pass, but the region register may be written.
// Commands are handled one at a time and every grain walk goes through the table's
// one read port and one write port at one grain per cycle: a push walks its clipped
// grain range, a test reads at most one grain, a pop walks the run and then the empty
// grains after it until the window end or the next owned grain, and a clear walks
// the window. Results of test and pop sit in an output register and leave on the
// master stream; the block stalls only if a second result is ready before the first
// one has been taken.

module grain_last_writer_map (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data,       // region_grains
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // msg_id, grain_start, grain_count, zero fill
    input  logic [1:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // may_write, run_found, run_id, run_start,
                                        // run_length, zero fill
    output logic        m_axis_tuser    // result_kind
);

    localparam int AW  = glwm_pkg::ADDR_W;
    localparam int SW  = glwm_pkg::SIZE_W;
    localparam int IDW = glwm_pkg::ID_WIDTH;

    glwm_pkg::state_t   state_reg, state_next;
    logic [AW-1:0]      cur_reg, cur_next;
    logic [AW-1:0]      last_reg, last_next;
    logic [IDW-1:0]     mark_reg, mark_next;
    logic               first_reg, first_next;
    logic               skip_reg, skip_next;
    logic [SW-1:0]      len_reg, len_next;
    logic [AW-1:0]      low_reg, low_next;
    logic [AW-1:0]      high_reg, high_next;
    logic               empty_reg, empty_next;
    logic [SW-1:0]      region_reg;
    glwm_pkg::result_t  res_reg, res_next;
    glwm_pkg::result_t  out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    glwm_pkg::ram_req_t ram_req;
    logic [IDW-1:0]     rd_data;

    logic               in_xfer;
    glwm_pkg::cmd_t     in_cmd;
    logic [IDW-1:0]     in_id;
    logic [SW-1:0]      in_start;
    logic [SW-1:0]      in_count;
    logic [SW-1:0]      size;
    logic [SW:0]        end_sum;
    logic [SW-1:0]      end_clip;
    logic [SW-1:0]      last_push;
    logic [IDW-1:0]     push_mark;
    logic [IDW-1:0]     owner;
    logic               out_free;

    glwm_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == glwm_pkg::ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign in_cmd   = glwm_pkg::cmd_t'(s_axis_tuser);
    assign in_id    = s_axis_tdata[15:0];
    assign in_start = s_axis_tdata[28:16];
    assign in_count = s_axis_tdata[41:29];

    assign size      = (region_reg > SW'(glwm_pkg::GRAIN_DEPTH)) ?
                       SW'(glwm_pkg::GRAIN_DEPTH) : region_reg;
    assign end_sum   = {1'b0, in_start} + {1'b0, in_count};
    assign end_clip  = (end_sum > {1'b0, size}) ? size : end_sum[SW-1:0];
    assign last_push = end_clip - 1'b1;
    assign push_mark = (in_id == glwm_pkg::ID_MAX) ? glwm_pkg::ID_MAX : in_id + 1'b1;
    assign owner     = first_reg ? rd_data : mark_reg;
    assign out_free  = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {5'b0, out_reg.run_length, out_reg.run_start, out_reg.run_id,
                            out_reg.run_found, out_reg.may_write};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= glwm_pkg::ST_INIT;
            cur_reg       <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            empty_reg     <= 1'b1;
            region_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                region_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg  <= last_next;
        mark_reg  <= mark_next;
        first_reg <= first_next;
        skip_reg  <= skip_next;
        len_reg   <= len_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        last_next      = last_reg;
        mark_next      = mark_reg;
        first_next     = first_reg;
        skip_next      = skip_reg;
        len_next       = len_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        empty_next     = empty_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_req        = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            glwm_pkg::ST_INIT:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = cur_reg;
                ram_req.wdata = '0;
                cur_next      = cur_reg + 1'b1;
                if (cur_reg == AW'(glwm_pkg::GRAIN_DEPTH - 1))
                begin
                    state_next = glwm_pkg::ST_IDLE;
                end
            end

            glwm_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    res_next = '0;
                    case (in_cmd)
                        glwm_pkg::CMD_PUSH:
                        begin
                            if (in_count != '0 && in_start < size)
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = in_start[AW-1:0];
                                cur_next      = in_start[AW-1:0];
                                last_next     = last_push[AW-1:0];
                                mark_next     = push_mark;
                                state_next    = glwm_pkg::ST_PUSH;
                                empty_next    = 1'b0;
                                if (empty_reg || in_start[AW-1:0] < low_reg)
                                begin
                                    low_next = in_start[AW-1:0];
                                end
                                if (empty_reg || last_push[AW-1:0] > high_reg)
                                begin
                                    high_next = last_push[AW-1:0];
                                end
                            end
                        end

                        glwm_pkg::CMD_TEST:
                        begin
                            res_next.kind = 1'b0;
                            if (in_start >= size)
                            begin
                                res_next.may_write = 1'b1;
                                state_next         = glwm_pkg::ST_EMIT;
                            end
                            else
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = in_start[AW-1:0];
                                mark_next     = in_id;
                                state_next    = glwm_pkg::ST_TEST;
                            end
                        end

                        glwm_pkg::CMD_POP:
                        begin
                            res_next.kind = 1'b1;
                            if (empty_reg)
                            begin
                                state_next = glwm_pkg::ST_EMIT;
                            end
                            else
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = low_reg;
                                cur_next      = low_reg;
                                last_next     = high_reg;
                                first_next    = 1'b1;
                                skip_next     = 1'b0;
                                len_next      = '0;
                                state_next    = glwm_pkg::ST_POP;
                            end
                        end

                        glwm_pkg::CMD_CLEAR:
                        begin
                            if (!empty_reg)
                            begin
                                cur_next   = low_reg;
                                last_next  = high_reg;
                                state_next = glwm_pkg::ST_CLEAR;
                            end
                        end

                        default:
                        begin
                            state_next = glwm_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            glwm_pkg::ST_PUSH:
            begin
                // Read of the next grain overlaps the write-back of the current one.
                ram_req.we    = 1'b1;
                ram_req.waddr = cur_reg;
                ram_req.wdata = (rd_data < mark_reg) ? mark_reg : rd_data;
                if (cur_reg == last_reg)
                begin
                    state_next = glwm_pkg::ST_IDLE;
                end
                else
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = cur_reg + 1'b1;
                    cur_next      = cur_reg + 1'b1;
                end
            end

            glwm_pkg::ST_TEST:
            begin
                res_next.may_write = (mark_reg >= rd_data);
                state_next         = glwm_pkg::ST_EMIT;
            end

            glwm_pkg::ST_POP:
            begin
                first_next = 1'b0;
                if (!skip_reg && (first_reg || rd_data == mark_reg))
                begin
                    // Grain belongs to the run: clear it and count it.
                    mark_next     = owner;
                    ram_req.we    = 1'b1;
                    ram_req.waddr = cur_reg;
                    ram_req.wdata = '0;
                    len_next      = len_reg + 1'b1;
                    if (cur_reg == last_reg)
                    begin
                        res_next.run_found  = 1'b1;
                        res_next.run_id     = (owner != '0) ? owner - 1'b1 : '0;
                        res_next.run_start  = low_reg;
                        res_next.run_length = len_reg + 1'b1;
                        empty_next          = 1'b1;
                        low_next            = '0;
                        high_next           = '0;
                        state_next          = glwm_pkg::ST_EMIT;
                    end
                    else
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = cur_reg + 1'b1;
                        cur_next      = cur_reg + 1'b1;
                    end
                end
                else
                begin
                    if (!skip_reg)
                    begin
                        skip_next           = 1'b1;
                        res_next.run_found  = 1'b1;
                        res_next.run_id     = (mark_reg != '0) ? mark_reg - 1'b1 : '0;
                        res_next.run_start  = low_reg;
                        res_next.run_length = len_reg;
                    end
                    if (rd_data != '0)
                    begin
                        low_next   = cur_reg;
                        state_next = glwm_pkg::ST_EMIT;
                    end
                    else if (cur_reg == last_reg)
                    begin
                        empty_next = 1'b1;
                        low_next   = '0;
                        high_next  = '0;
                        state_next = glwm_pkg::ST_EMIT;
                    end
                    else
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = cur_reg + 1'b1;
                        cur_next      = cur_reg + 1'b1;
                    end
                end
            end

            glwm_pkg::ST_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = cur_reg;
                ram_req.wdata = '0;
                cur_next      = cur_reg + 1'b1;
                if (cur_reg == last_reg)
                begin
                    empty_next = 1'b1;
                    low_next   = '0;
                    high_next  = '0;
                    state_next = glwm_pkg::ST_IDLE;
                end
            end

            glwm_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = glwm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = glwm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/glwm_ram.sv =====
// Owner table: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module glwm_ram (
    input  logic                             clk,
    input  glwm_pkg::ram_req_t               req,
    output logic [glwm_pkg::ID_WIDTH-1:0]    rd_data
);

    logic [glwm_pkg::ID_WIDTH-1:0] mem [glwm_pkg::GRAIN_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_data <= mem[req.raddr];
        end
    end

endmodule
